>>> rtl/core/ppm_pkg.sv
// Shared types and constants of the PPM frame decoder.
// Depends on nothing; every other file of the block but ppm_stream_if imports it.
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

  // Field and register widths
  localparam int TS_W         = 16;
  localparam int VAL_W        = 16;
  localparam int FRESH_W      = 8;
  localparam int SLOT_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int CHANNELS_MAX = 6;
  localparam int CHANNELS_DEF = 6;

  // Operation and status codes
  localparam logic OP_EDGE      = 1'b0;
  localparam logic OP_QUERY     = 1'b1;
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_TIMEOUT = 1'b1;

  // Divide by three: multiply by ceil(2^17 / 3), exact for 16-bit widths
  localparam int                DIV3_SHIFT = 17;
  localparam logic [DIV3_SHIFT-1:0] DIV3_MUL = 17'd43691;

  // Register reset values
  localparam logic [VAL_W-1:0]   SHORT_LIMIT_RST  = 16'd2700;
  localparam logic [VAL_W-1:0]   DATA_LIMIT_RST   = 16'd6300;
  localparam logic [VAL_W-1:0]   SYNC_MIN_RST     = 16'd9000;
  localparam logic [VAL_W-1:0]   SYNC_MAX_RST     = 16'd60000;
  localparam logic [FRESH_W-1:0] FRESH_RELOAD_RST = 8'd20;
  localparam logic [VAL_W-1:0]   VALID_MIN_RST    = 16'd900;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_LIMIT  = 3'd0,
    REG_DATA_LIMIT   = 3'd1,
    REG_SYNC_MIN     = 3'd2,
    REG_SYNC_MAX     = 3'd3,
    REG_FRESH_RELOAD = 3'd4,
    REG_VALID_MIN    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [VAL_W-1:0]   short_limit;
    logic [VAL_W-1:0]   data_limit;
    logic [VAL_W-1:0]   sync_min;
    logic [VAL_W-1:0]   sync_max;
    logic [FRESH_W-1:0] fresh_reload;
    logic [VAL_W-1:0]   valid_min;
  } cfg_t;

  // Pulse width classes
  typedef enum logic [2:0] {
    PW_ERROR = 3'b001,
    PW_SYNC  = 3'b010,
    PW_DATA  = 3'b100
  } pw_class_t;

  // Input item
  typedef struct packed {
    logic            operation;
    logic [TS_W-1:0] timestamp;
  } req_t;

  // Result item
  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] chan_a;
    logic [VAL_W-1:0] chan_b;
    logic [VAL_W-1:0] chan_c;
    logic [VAL_W-1:0] chan_d;
    logic [VAL_W-1:0] chan_e;
    logic [VAL_W-1:0] chan_f;
    logic [VAL_W-1:0] error_count;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/ppm_stream_if.sv
// Valid/ready stream channel used for the item and result ports.
// Payload type is set at instantiation (ppm_pkg::req_t or ppm_pkg::rsp_t).
`timescale 1ns / 1ps
`default_nettype none

interface ppm_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> rtl/core/ppm_cfg_regs.sv
// Configuration register bank of the PPM frame decoder.
// Depends on ppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_en,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ppm_pkg::cfg_t                   cfg
);
  import ppm_pkg::*;

  // Write decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_limit  <= SHORT_LIMIT_RST;
      cfg.data_limit   <= DATA_LIMIT_RST;
      cfg.sync_min     <= SYNC_MIN_RST;
      cfg.sync_max     <= SYNC_MAX_RST;
      cfg.fresh_reload <= FRESH_RELOAD_RST;
      cfg.valid_min    <= VALID_MIN_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_SHORT_LIMIT:  cfg.short_limit  <= cfg_data[VAL_W-1:0];
        REG_DATA_LIMIT:   cfg.data_limit   <= cfg_data[VAL_W-1:0];
        REG_SYNC_MIN:     cfg.sync_min     <= cfg_data[VAL_W-1:0];
        REG_SYNC_MAX:     cfg.sync_max     <= cfg_data[VAL_W-1:0];
        REG_FRESH_RELOAD: cfg.fresh_reload <= cfg_data[FRESH_W-1:0];
        REG_VALID_MIN:    cfg.valid_min    <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ppm_pulse_class.sv
// Pulse width classifier and tick-to-microsecond scaler (width / 3).
// Depends on ppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppm_pulse_class (
  input  ppm_pkg::cfg_t                 cfg,
  input  logic [ppm_pkg::TS_W-1:0]      width,
  output ppm_pkg::pw_class_t            cls,
  output logic [ppm_pkg::VAL_W-1:0]     quotient
);
  import ppm_pkg::*;

  localparam int PROD_W = TS_W + DIV3_SHIFT;

  logic              is_err;
  logic [PROD_W-1:0] prod;

  // Error tests take precedence; the sync minimum itself counts as sync
  assign is_err = (width < cfg.short_limit)
               || ((width > cfg.data_limit) && (width < cfg.sync_min))
               || (width > cfg.sync_max);

  always_comb begin
    priority if (is_err) begin
      cls = PW_ERROR;
    end else if (width >= cfg.sync_min) begin
      cls = PW_SYNC;
    end else begin
      cls = PW_DATA;
    end
  end

  // Reciprocal multiply, exact for every 16-bit width
  assign prod     = PROD_W'(width) * PROD_W'(DIV3_MUL);
  assign quotient = prod[DIV3_SHIFT +: VAL_W];

endmodule

`default_nettype wire

>>> rtl/core/ppm_frame_track.sv
// Frame state of the PPM decoder: slot buffer, held channels, error count,
// freshness, and the query result. Depends on ppm_pkg and ppm_pulse_class.
`timescale 1ns / 1ps
`default_nettype none

module ppm_frame_track #(
  parameter int CHANNELS = ppm_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  ppm_pkg::cfg_t cfg,
  input  logic          go,
  input  ppm_pkg::req_t item,
  output ppm_pkg::rsp_t result
);
  import ppm_pkg::*;

  localparam int                IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_FULL   = SLOT_W'(CHANNELS);
  localparam logic [SLOT_W-1:0] SLOT_POISON = SLOT_W'(CHANNELS + 1);

  logic [TS_W-1:0]    last_edge;
  logic [SLOT_W-1:0]  slot_index;
  logic [VAL_W-1:0]   frame_buf [CHANNELS];
  logic [VAL_W-1:0]   held      [CHANNELS];
  logic [VAL_W-1:0]   errors;
  logic [FRESH_W-1:0] freshness;

  logic [TS_W-1:0]    width;
  pw_class_t          cls;
  logic [VAL_W-1:0]   quotient;
  logic               all_valid;
  logic [VAL_W-1:0]   chan_out  [CHANNELS_MAX];

  // Wrapping width since the previous edge
  assign width = item.timestamp - last_edge;

  ppm_pulse_class u_class (
    .cfg      (cfg),
    .width    (width),
    .cls      (cls),
    .quotient (quotient)
  );

  // State update per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge  <= '0;
      slot_index <= '0;
      errors     <= '0;
      freshness  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        frame_buf[i] <= '0;
        held[i]      <= '0;
      end
    end else if (go) begin
      if (item.operation == OP_EDGE) begin
        last_edge <= item.timestamp;
        unique case (cls)
          PW_ERROR: begin
            errors     <= errors + 1'b1;
            slot_index <= SLOT_POISON;
          end
          PW_SYNC: begin
            // Commit only an unpoisoned frame
            if (slot_index <= SLOT_FULL) begin
              for (int i = 0; i < CHANNELS; i++) begin
                held[i] <= frame_buf[i];
              end
              freshness <= cfg.fresh_reload;
            end
            slot_index <= '0;
          end
          PW_DATA: begin
            // Extra channels and poisoned frames drop the pulse
            if (slot_index < SLOT_FULL) begin
              frame_buf[slot_index[IDX_W-1:0]] <= quotient;
              slot_index <= slot_index + 1'b1;
            end
          end
          default: ;
        endcase
      end else if (freshness != '0) begin
        freshness <= freshness - 1'b1;
      end
    end
  end

  // Query evaluation against the current held values
  always_comb begin
    all_valid = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (held[i] < cfg.valid_min) begin
        all_valid = 1'b0;
      end
    end
  end

  // Unused channel fields read as zero
  for (genvar g = 0; g < CHANNELS_MAX; g++) begin : g_chan
    if (g < CHANNELS) begin : g_used
      assign chan_out[g] = held[g];
    end else begin : g_unused
      assign chan_out[g] = '0;
    end
  end

  assign result.status      = ((freshness != '0) && all_valid) ? STAT_OK : STAT_TIMEOUT;
  assign result.chan_a      = chan_out[0];
  assign result.chan_b      = chan_out[1];
  assign result.chan_c      = chan_out[2];
  assign result.chan_d      = chan_out[3];
  assign result.chan_e      = chan_out[4];
  assign result.chan_f      = chan_out[5];
  assign result.error_count = errors;

endmodule

`default_nettype wire

>>> rtl/core/ppm_frame_decoder.sv
// PPM frame decoder top level: input register, frame state, result register.
// A query moves from the input register through the frame state into the result register.
// Throughput: one item per cycle while no query stalls; an edge item makes no result and
// never waits on the result port. A query stalls only while the result register is full and unread.
// Reset (synchronous): registers return to their defaults, frame state and valid flags clear.
// Depends on ppm_pkg, ppm_stream_if, ppm_cfg_regs, ppm_frame_track.
`timescale 1ns / 1ps
`default_nettype none

module ppm_frame_decoder #(
  parameter int CHANNELS = ppm_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_en,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppm_pkg::CFG_DATA_W-1:0] cfg_data,
  ppm_stream_if.sink                     req,
  ppm_stream_if.source                   rsp
);
  import ppm_pkg::*;

  cfg_t cfg;
  logic in_valid;
  req_t in_item;
  logic advance;
  rsp_t result;
  logic out_valid;
  rsp_t out_item;

  ppm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Held item moves on unless it is a query facing a full result register that is not being read
  assign advance   = in_valid
                  && ((in_item.operation == OP_EDGE) || !out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_item <= req.data;
    end
  end

  ppm_frame_track #(
    .CHANNELS (CHANNELS)
  ) u_track (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .go     (advance),
    .item   (in_item),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (in_item.operation == OP_QUERY)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (in_item.operation == OP_QUERY)) begin
      out_item <= result;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for ppm_frame_decoder: a directed table of edges and queries, then random PPM
// frames under six register settings; results checked against a local decoding model, pinned rows against the table.
// Depends on ppm_pkg, ppm_stream_if and ppm_frame_decoder from the RTL.

module testbench;
  import ppm_pkg::*;

  localparam int NUM_CH         = CHANNELS_DEF;
  localparam int STALL_LIMIT    = 4000;
  localparam int PHASE_ITEMS    = 150;
  localparam int NUM_PHASES     = 6;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_LEN       = 300;
  localparam int SETTLE_CYC     = 4;
  localparam int MAX_PRINTS     = 50;

  logic                  clk;
  logic                  rst;
  logic                  cfg_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppm_stream_if #(.payload_t(req_t)) req_if ();
  ppm_stream_if #(.payload_t(rsp_t)) rsp_if ();

  ppm_frame_decoder #(.CHANNELS(NUM_CH)) DUT (
    .clk(clk), .rst(rst),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_if), .rsp(rsp_if)
  );

  // Decoder model state
  cfg_t               trk_cfg;
  logic [TS_W-1:0]    trk_last_edge;
  logic [SLOT_W-1:0]  trk_slot;
  logic [VAL_W-1:0]   trk_frame [NUM_CH];
  logic [VAL_W-1:0]   trk_held  [NUM_CH];
  logic [VAL_W-1:0]   trk_errors;
  logic [FRESH_W-1:0] trk_fresh;
  rsp_t               pending_status [$];

  // Sender and receiver controls
  logic [TS_W-1:0]  stamp_now;
  bit               pin_on;
  logic             pin_status;
  logic [VAL_W-1:0] pin_errs;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_left;

  // Run statistics
  int fail_count;
  int items_issued;
  int items_taken;
  int results_seen;
  int widths_rejected;
  int idle_run;

  // Directed table; pinned rows carry status and error count read straight off the spec
  typedef struct {
    logic             op;
    logic [TS_W-1:0]  stamp;
    bit               pinned;
    logic             pin_st;
    logic [VAL_W-1:0] pin_err;
  } row_t;

  row_t directed_rows [22] = '{
    '{OP_QUERY, 16'd0,     1'b1, STAT_TIMEOUT, 16'd0}, // nothing committed after reset
    '{OP_EDGE,  16'd0,     1'b0, STAT_OK,      16'd0}, // first edge, zero width: error
    '{OP_EDGE,  16'd12000, 1'b0, STAT_OK,      16'd0}, // sync on poisoned frame: no commit
    '{OP_QUERY, 16'hFFFF,  1'b1, STAT_TIMEOUT, 16'd1}, // still no freshness
    '{OP_EDGE,  16'd14700, 1'b0, STAT_OK,      16'd0}, // width at short limit
    '{OP_EDGE,  16'd21000, 1'b0, STAT_OK,      16'd0}, // width at data limit
    '{OP_EDGE,  16'd24000, 1'b0, STAT_OK,      16'd0},
    '{OP_EDGE,  16'd28500, 1'b0, STAT_OK,      16'd0},
    '{OP_EDGE,  16'd33500, 1'b0, STAT_OK,      16'd0},
    '{OP_EDGE,  16'd39500, 1'b0, STAT_OK,      16'd0},
    '{OP_EDGE,  16'd42800, 1'b0, STAT_OK,      16'd0}, // seventh channel is dropped
    '{OP_EDGE,  16'd51800, 1'b0, STAT_OK,      16'd0}, // width equal to sync minimum
    '{OP_QUERY, 16'd0,     1'b1, STAT_OK,      16'd1},
    '{OP_EDGE,  16'd46264, 1'b0, STAT_OK,      16'd0}, // sync at sync max, timer wraps
    '{OP_EDGE,  16'd40729, 1'b0, STAT_OK,      16'd0}, // one above sync max: error
    '{OP_EDGE,  16'd47729, 1'b0, STAT_OK,      16'd0}, // gap between data and sync: error
    '{OP_EDGE,  16'd47728, 1'b0, STAT_OK,      16'd0}, // largest width: error
    '{OP_QUERY, 16'd0,     1'b1, STAT_OK,      16'd4}, // earlier commit still fresh
    '{OP_EDGE,  16'd57228, 1'b0, STAT_OK,      16'd0}, // sync on poisoned frame
    '{OP_EDGE,  16'd60078, 1'b0, STAT_OK,      16'd0},
    '{OP_EDGE,  16'd4542,  1'b0, STAT_OK,      16'd0}, // short frame commits
    '{OP_QUERY, 16'h5A5A,  1'b0, STAT_OK,      16'd0}
  };

  // Register settings of the random phases, extremes included
  cfg_t phase_cfg [NUM_PHASES] = '{
    '{16'd2700,  16'd6300,  16'd9000,  16'd60000, 8'd20,  16'd900},
    '{16'd1500,  16'd5000,  16'd7000,  16'd30000, 8'd3,   16'd600},
    '{16'd0,     16'd65535, 16'd65535, 16'd65535, 8'd255, 16'd0},
    '{16'd65535, 16'd0,     16'd0,     16'd0,     8'd0,   16'd65535},
    '{16'd2000,  16'd8000,  16'd6000,  16'd20000, 8'd1,   16'd1000},
    '{16'd2700,  16'd6300,  16'd9000,  16'd60000, 8'd20,  16'd2000}
  };
  int phase_idle  [NUM_PHASES] = '{0, 72, 0, 35, 35, 0};
  int phase_stall [NUM_PHASES] = '{0, 0, 72, 35, 35, 0};

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    if (fail_count < MAX_PRINTS)
      $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
    fail_count++;
  endtask

  function automatic void reset_model();
    trk_cfg       = '{SHORT_LIMIT_RST, DATA_LIMIT_RST, SYNC_MIN_RST, SYNC_MAX_RST,
                      FRESH_RELOAD_RST, VALID_MIN_RST};
    trk_last_edge = '0;
    trk_slot      = '0;
    trk_errors    = '0;
    trk_fresh     = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      trk_frame[i] = '0;
      trk_held[i]  = '0;
    end
  endfunction

  // Error tests come first; anything left at or above sync minimum is sync
  function automatic pw_class_t classify_width(logic [VAL_W-1:0] w);
    if (w < trk_cfg.short_limit || (w > trk_cfg.data_limit && w < trk_cfg.sync_min) ||
        w > trk_cfg.sync_max)
      return PW_ERROR;
    if (w >= trk_cfg.sync_min)
      return PW_SYNC;
    return PW_DATA;
  endfunction

  // Advance the model by one item; returns 1 when a status result is due
  function automatic bit decode_item(input req_t item, output rsp_t res);
    logic [VAL_W-1:0] w;
    logic [VAL_W-1:0] vals [CHANNELS_MAX];
    bit               ok;
    res = '0;
    if (item.operation == OP_EDGE) begin
      w = item.timestamp - trk_last_edge;
      case (classify_width(w))
        PW_ERROR: begin
          trk_errors = trk_errors + 1'b1;
          trk_slot   = SLOT_W'(NUM_CH + 1);
          widths_rejected++;
        end
        PW_SYNC: begin
          if (trk_slot <= NUM_CH) begin
            trk_held  = trk_frame;
            trk_fresh = trk_cfg.fresh_reload;
          end
          trk_slot = '0;
        end
        default: begin
          if (trk_slot < NUM_CH) begin
            trk_frame[trk_slot] = VAL_W'(w / 3);
            trk_slot = trk_slot + 1'b1;
          end
        end
      endcase
      trk_last_edge = item.timestamp;
      return 1'b0;
    end
    // Query: spend freshness, then every held channel must reach the minimum
    ok = (trk_fresh != 0);
    if (ok) begin
      trk_fresh = trk_fresh - 1'b1;
      for (int i = 0; i < NUM_CH; i++)
        if (trk_held[i] < trk_cfg.valid_min) ok = 1'b0;
    end
    for (int i = 0; i < CHANNELS_MAX; i++)
      vals[i] = (i < NUM_CH) ? trk_held[i] : '0;
    res.status      = ok ? STAT_OK : STAT_TIMEOUT;
    res.chan_a      = vals[0];
    res.chan_b      = vals[1];
    res.chan_c      = vals[2];
    res.chan_d      = vals[3];
    res.chan_e      = vals[4];
    res.chan_f      = vals[5];
    res.error_count = trk_errors;
    return 1'b1;
  endfunction

  task automatic check_result(rsp_t got, rsp_t want);
    if (got.status !== want.status)
      report_mismatch("status", VAL_W'(got.status), VAL_W'(want.status));
    if (got.chan_a !== want.chan_a) report_mismatch("chan_a", got.chan_a, want.chan_a);
    if (got.chan_b !== want.chan_b) report_mismatch("chan_b", got.chan_b, want.chan_b);
    if (got.chan_c !== want.chan_c) report_mismatch("chan_c", got.chan_c, want.chan_c);
    if (got.chan_d !== want.chan_d) report_mismatch("chan_d", got.chan_d, want.chan_d);
    if (got.chan_e !== want.chan_e) report_mismatch("chan_e", got.chan_e, want.chan_e);
    if (got.chan_f !== want.chan_f) report_mismatch("chan_f", got.chan_f, want.chan_f);
    if (got.error_count !== want.error_count)
      report_mismatch("error_count", got.error_count, want.error_count);
  endtask

  // Monitor: check results against the oldest expectation, then predict accepted items
  always @(posedge clk) begin
    rsp_t want;
    rsp_t made;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (pending_status.size() == 0) begin
          report_mismatch("result with none pending", '0, '0);
        end else begin
          want = pending_status.pop_front();
          check_result(rsp_if.data, want);
        end
      end
      if (req_if.valid && req_if.ready) begin
        items_taken++;
        if (decode_item(req_if.data, made)) begin
          if (pin_on) begin
            made.status      = pin_status;
            made.error_count = pin_errs;
          end
          pending_status.push_back(made);
        end
      end
    end
  end

  // Watchdog on cycles where no item moves on either side
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result receiver: long hold-off when requested, random stalls otherwise
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready = 1'b0;
    end else if (hold_left > 0) begin
      rsp_if.ready = 1'b0;
      hold_left--;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(req_t item, bit pinned, logic st, logic [VAL_W-1:0] errs);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.data  = item;
    pin_on       = pinned;
    pin_status   = st;
    pin_errs     = errs;
    items_issued++;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic send_edge(logic [VAL_W-1:0] width);
    req_t item;
    stamp_now      = stamp_now + width;
    item.operation = OP_EDGE;
    item.timestamp = stamp_now;
    send_item(item, 1'b0, STAT_OK, '0);
  endtask

  task automatic send_query();
    req_t item;
    item.operation = OP_QUERY;
    item.timestamp = TS_W'($urandom);
    send_item(item, 1'b0, STAT_OK, '0);
  endtask

  // Width pickers biased toward the range ends
  function automatic logic [VAL_W-1:0] pick_in(int lo, int hi);
    case ($urandom_range(7))
      0:       return VAL_W'(lo);
      1:       return VAL_W'(hi);
      default: return VAL_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] data_width();
    int lo;
    int hi;
    lo = trk_cfg.short_limit;
    hi = trk_cfg.data_limit;
    if (trk_cfg.sync_min != 0 && hi >= int'(trk_cfg.sync_min)) hi = trk_cfg.sync_min - 1;
    if (lo > hi) return VAL_W'($urandom);
    return pick_in(lo, hi);
  endfunction

  function automatic logic [VAL_W-1:0] sync_width();
    int lo;
    int hi;
    lo = (trk_cfg.sync_min > trk_cfg.short_limit) ? trk_cfg.sync_min : trk_cfg.short_limit;
    hi = trk_cfg.sync_max;
    if (lo > hi) return VAL_W'($urandom);
    return pick_in(lo, hi);
  endfunction

  function automatic logic [VAL_W-1:0] bad_width();
    int s_lim;
    int d_lim;
    int s_min;
    int s_max;
    s_lim = trk_cfg.short_limit;
    d_lim = trk_cfg.data_limit;
    s_min = trk_cfg.sync_min;
    s_max = trk_cfg.sync_max;
    case ($urandom_range(2))
      0:       if (s_lim > 0) return pick_in(0, s_lim - 1);
      1:       if (s_max < 65535) return pick_in(s_max + 1, 65535);
      default: if (s_min > d_lim + 1) return pick_in(d_lim + 1, s_min - 1);
    endcase
    return VAL_W'($urandom);
  endfunction

  // One frame: mostly well formed, some noise and some poisoned frames
  task automatic send_frame();
    int roll;
    int n_data;
    roll = $urandom_range(99);
    if (roll < 8) begin
      send_edge(VAL_W'($urandom));
      return;
    end
    n_data = (roll < 60) ? NUM_CH : $urandom_range(NUM_CH + 2);
    for (int k = 0; k < n_data; k++) begin
      send_edge(data_width());
      if ($urandom_range(99) < 10) send_query();
    end
    if (roll < 18) send_edge(bad_width());
    send_edge(sync_width());
    repeat ($urandom_range(3)) send_query();
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_en    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
  endtask

  // Only called with the block idle
  task automatic apply_settings(cfg_t s);
    put_reg(REG_SHORT_LIMIT, s.short_limit);
    put_reg(REG_DATA_LIMIT, s.data_limit);
    put_reg(REG_SYNC_MIN, s.sync_min);
    put_reg(REG_SYNC_MAX, s.sync_max);
    put_reg(REG_FRESH_RELOAD, CFG_DATA_W'(s.fresh_reload));
    put_reg(REG_VALID_MIN, s.valid_min);
    cfg_en  = 1'b0;
    trk_cfg = s;
  endtask

  // Drain all pending results, then let any edge in flight finish
  task automatic settle();
    req_if.valid = 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Main sequence
  initial begin
    req_t item;
    int   target;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    cfg_en         = 1'b0;
    cfg_index      = REG_SHORT_LIMIT;
    cfg_data       = '0;
    pin_on         = 1'b0;
    pin_status     = STAT_OK;
    pin_errs       = '0;
    stamp_now      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    fail_count     = 0;
    items_issued   = 0;
    items_taken    = 0;
    results_seen   = 0;
    widths_rejected = 0;
    idle_run       = 0;
    reset_model();
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    foreach (directed_rows[r]) begin
      item.operation = directed_rows[r].op;
      item.timestamp = directed_rows[r].stamp;
      if (item.operation == OP_EDGE) stamp_now = item.timestamp;
      send_item(item, directed_rows[r].pinned, directed_rows[r].pin_st,
                directed_rows[r].pin_err);
    end
    settle();

    // Random frames under each register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_settings(phase_cfg[p]);
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      if (p == PRESSURE_PHASE) begin
        // receiver holds off while queries keep coming, so the input backs up
        hold_left = HOLD_LEN;
        repeat (8) send_query();
      end
      target = items_issued + PHASE_ITEMS;
      while (items_issued < target) send_frame();
      settle();
    end

    if (pending_status.size() != 0)
      report_mismatch("results never returned", VAL_W'(pending_status.size()), '0);

    $display("Covered %0d items (%0d from the directed table) over %0d register settings,",
             items_taken, $size(directed_rows), NUM_PHASES + 1);
    $display("with %0d status results checked and %0d rejected pulse widths.",
             results_seen, widths_rejected);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
